// File: rtl/core/double_ended_queue_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the double-ended queue.
// Every macro expects a clock named clk and an active-low reset named rst_n.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define DQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/dq_pkg.sv
// ---------------------------------------------------------------------------
// dq_pkg
// Command codes, error codes and the control-to-output status record.
// ---------------------------------------------------------------------------
package dq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef struct packed {
    logic load;   // read data is valid and the output register takes it
    logic empty;  // queue holds no words after the transaction
    err_t err;
  } dq_stat_t;

endpackage

// File: rtl/core/double_ended_queue.sv
// ---------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue on a ring of DEPTH memory slots.
// ---------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry a command (push back, push front,
// pop back, pop front, clear) and a word used by the push commands.
// Result channel: out_valid / out_stall carry, for every transaction, the
// front and back words (zero when empty), the element count, an empty flag
// and an error code (pop on empty, push on full; either leaves the queue
// unchanged).
// Each transaction runs in order: the slot write at accept, then a
// two-port registered read of the front and back slots, then the load
// into the output register. in_stall stays high until the load, so a new
// transaction is accepted only once the last one has been loaded.
// The output register holds a result while out_stall is high; the next
// transaction can already be accepted and waits in its load step until the
// register frees up.
// Reset (synchronous, rst_n low) empties the queue and drops any pending
// result; the slot memory is not cleared and needs no pass after reset.
// ---------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [2:0]                             in_cmd,
  input  logic signed [DATA_WIDTH-1:0]           in_push_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [DATA_WIDTH-1:0]           out_front_value,
  output logic signed [DATA_WIDTH-1:0]           out_back_value,
  output logic [$clog2(DEPTH + 1)-1:0]           out_element_count,
  output logic                                   out_is_empty,
  output logic [1:0]                             out_error_code
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dq_stat_t                     stat;
  logic [CW-1:0]                count;
  logic                         out_free;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic signed [DATA_WIDTH-1:0] wr_data;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr_a;
  logic [AW-1:0]                rd_addr_b;
  logic signed [DATA_WIDTH-1:0] rd_data_a;
  logic signed [DATA_WIDTH-1:0] rd_data_b;

  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] front_r;
  logic signed [DATA_WIDTH-1:0] back_r;
  logic [CW-1:0]                count_r;
  logic                         empty_r;
  err_t                         err_r;

  assign out_free = !out_valid_r || !out_stall;

  dq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_push_value (in_push_value),
    .out_free      (out_free),
    .stat          (stat),
    .count         (count),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr_a     (rd_addr_a),
    .rd_addr_b     (rd_addr_b)
  );

  dq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Zero the words of an empty queue; stale slots are never shown.
  always_ff @(posedge clk) begin
    if (stat.load) begin
      front_r <= stat.empty ? '0 : rd_data_a;
      back_r  <= stat.empty ? '0 : rd_data_b;
      count_r <= count;
      empty_r <= stat.empty;
      err_r   <= stat.err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_front_value   = front_r;
  assign out_back_value    = back_r;
  assign out_element_count = count_r;
  assign out_is_empty      = empty_r;
  assign out_error_code    = err_r;

endmodule

// File: rtl/core/dq_mem.sv
// ---------------------------------------------------------------------------
// dq_mem
// Slot storage: one write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
module dq_mem #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 4
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic signed [DATA_WIDTH-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr_a,
  input  logic [AW-1:0]                rd_addr_b,
  output logic signed [DATA_WIDTH-1:0] rd_data_a,
  output logic signed [DATA_WIDTH-1:0] rd_data_b
);

  logic signed [DATA_WIDTH-1:0] slot_mem_r [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_a_r;
  logic signed [DATA_WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= slot_mem_r[rd_addr_a];
      rd_b_r <= slot_mem_r[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// File: rtl/core/dq_ctrl.sv
// ---------------------------------------------------------------------------
// dq_ctrl
// Ring indexes, element count and the write / read / load sequencer.
// ---------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module dq_ctrl
  import dq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 4,
  parameter int CW         = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_cmd,
  input  logic signed [DATA_WIDTH-1:0] in_push_value,
  input  logic                         out_free,
  output dq_stat_t                     stat,
  output logic [CW-1:0]                count,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic signed [DATA_WIDTH-1:0] wr_data,
  output logic                         rd_en,
  output logic [AW-1:0]                rd_addr_a,
  output logic [AW-1:0]                rd_addr_b
);

  localparam int SW = CW + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t        st_r, st_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  err_t          err_r, err_nxt;
  logic          acc;
  logic          full;
  logic          empty;
  logic          push_cmd;

  // Reduce a sum below twice the depth to a ring position.
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] d;
    d = s - SW'(DEPTH);
    return (s >= SW'(DEPTH)) ? d[AW-1:0] : s[AW-1:0];
  endfunction

  assign acc      = in_valid && (st_r == S_IDLE);
  assign in_stall = (st_r != S_IDLE);
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign push_cmd = (in_cmd == CMD_PUSH_BACK) || (in_cmd == CMD_PUSH_FRONT);
  assign wr_data  = in_push_value;

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    wr_en     = 1'b0;
    wr_addr   = front_r;
    if (acc) begin
      err_nxt = ERR_NONE;
      case (in_cmd)
        CMD_PUSH_BACK: begin
          if (full) begin
            err_nxt = ERR_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = wrap(SW'(front_r) + SW'(count_r));
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_PUSH_FRONT: begin
          if (full) begin
            err_nxt = ERR_FULL;
          end else begin
            front_nxt = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
            wr_en     = 1'b1;
            wr_addr   = front_nxt;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            err_nxt = ERR_EMPTY;
          end else begin
            count_nxt = count_r - CW'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            err_nxt = ERR_EMPTY;
          end else begin
            front_nxt = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
            count_nxt = count_r - CW'(1);
          end
        end
        CMD_CLEAR: begin
          front_nxt = '0;
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Reads go out the cycle after the write, so the same entry never sees
  // a read and a write at one edge.
  assign rd_en     = (st_r == S_RD);
  assign rd_addr_a = front_r;
  assign rd_addr_b = empty ? front_r
                           : wrap(SW'(front_r) + SW'(count_r) - SW'(1));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (acc) st_nxt = S_RD;
      S_RD:    st_nxt = S_LOAD;
      S_LOAD:  if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      front_r <= '0;
      count_r <= '0;
      err_r   <= ERR_NONE;
    end else begin
      st_r    <= st_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

  assign stat.load  = (st_r == S_LOAD) && out_free;
  assign stat.empty = empty;
  assign stat.err   = err_r;
  assign count      = count_r;

  `DQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "count above depth")
  `DQ_ASSERT_IMP(a_front_bound, 1'b1, front_r <= AW'(DEPTH - 1), "front index out of ring")
  `DQ_ASSERT_NXT(a_acc_then_read, acc, st_r == S_RD, "accepted transaction skipped read")
  `DQ_ASSERT_NXT(a_full_push_hold, acc && full && push_cmd, $stable(count_r) && !$past(wr_en),
                 "push on full queue changed state")

endmodule

// File: tb/sv/double_ended_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the ring-buffer double-ended queue. A directed
// table walks the empty, full and wrap-around corners, then random command
// streams drift between filling and draining under four idle/stall mixes.
// Each result is checked against its table row or an in-bench deque model.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int DW           = 32;
  localparam int CW           = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1380;
  localparam int PHASES       = 4;
  localparam int PEND_DEPTH   = 64;

  // Unassigned command encodings; the block must treat them as no-ops.
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  typedef struct packed {
    logic signed [DW-1:0] front;
    logic signed [DW-1:0] back;
    logic [CW-1:0]        count;
    logic                 empty;
    err_t                 err;
  } deque_status_t;

  typedef struct packed {
    logic [2:0]    cmd;
    logic [DW-1:0] value;
    int            reps;
    bit            typed;
    deque_status_t status;
  } script_row_t;

  localparam int NROWS = 23;

  localparam script_row_t SCRIPT [NROWS] = '{
    '{CMD_POP_BACK,   32'h0000_0000,  1, 1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, ERR_EMPTY}},
    '{CMD_POP_FRONT,  32'h0000_0000,  1, 1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, ERR_EMPTY}},
    '{CMD_PUSH_BACK,  32'h7FFF_FFFF,  1, 1'b1,
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b0, ERR_NONE}},
    '{CMD_PUSH_FRONT, 32'h8000_0000,  1, 1'b1,
      '{32'h8000_0000, 32'h7FFF_FFFF, 5'd2, 1'b0, ERR_NONE}},
    '{CMD_POP_BACK,   32'hFFFF_FFFF,  1, 1'b1,
      '{32'h8000_0000, 32'h8000_0000, 5'd1, 1'b0, ERR_NONE}},
    '{CMD_POP_FRONT,  32'h0000_0000,  1, 1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, ERR_NONE}},
    '{CMD_PUSH_FRONT, 32'hFFFF_FFFF,  1, 1'b1,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0, ERR_NONE}},
    '{CMD_PUSH_BACK,  32'h0000_0001,  1, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0001, 5'd2, 1'b0, ERR_NONE}},
    '{CMD_SPARE_A,    32'hDEAD_BEEF,  1, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0001, 5'd2, 1'b0, ERR_NONE}},
    '{CMD_SPARE_B,    32'hDEAD_BEEF,  1, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0001, 5'd2, 1'b0, ERR_NONE}},
    '{CMD_SPARE_C,    32'hDEAD_BEEF,  1, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0001, 5'd2, 1'b0, ERR_NONE}},
    '{CMD_CLEAR,      32'h0000_0000,  1, 1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, ERR_NONE}},
    '{CMD_POP_FRONT,  32'h0000_0000,  1, 1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, ERR_EMPTY}},
    '{CMD_PUSH_BACK,  32'h0000_0000,  1, 1'b1, '{32'h0, 32'h0, 5'd1, 1'b0, ERR_NONE}},
    '{CMD_PUSH_BACK,  32'h5A5A_5A5A, 15, 1'b0, '0},
    '{CMD_PUSH_FRONT, 32'h1234_5678,  1, 1'b1,
      '{32'h0000_0000, 32'h5A5A_5A5A, 5'd16, 1'b0, ERR_FULL}},
    '{CMD_PUSH_BACK,  32'h1234_5678,  1, 1'b1,
      '{32'h0000_0000, 32'h5A5A_5A5A, 5'd16, 1'b0, ERR_FULL}},
    '{CMD_POP_FRONT,  32'h0000_0000, 16, 1'b0, '0},
    '{CMD_POP_BACK,   32'h0000_0000,  1, 1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, ERR_EMPTY}},
    // front index wraps below slot zero here
    '{CMD_PUSH_FRONT, 32'hA5A5_A5A5, 16, 1'b0, '0},
    '{CMD_PUSH_BACK,  32'h0000_0001,  1, 1'b1,
      '{32'hA5A5_A5A5, 32'hA5A5_A5A5, 5'd16, 1'b0, ERR_FULL}},
    '{CMD_POP_BACK,   32'h0000_0000,  5, 1'b0, '0},
    '{CMD_CLEAR,      32'h0000_0000,  1, 1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, ERR_NONE}}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           in_cmd;
  logic signed [DW-1:0] in_push_value;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [DW-1:0] out_front_value;
  logic signed [DW-1:0] out_back_value;
  logic [CW-1:0]        out_element_count;
  logic                 out_is_empty;
  logic [1:0]           out_error_code;

  // Deque model state
  logic [DW-1:0] ring_word [DEPTH];
  logic [3:0]    ring_head;
  logic [CW-1:0] ring_fill;

  // Expected results in flight, kept as a small ring
  deque_status_t pend_buf [PEND_DEPTH];
  int            pend_wr = 0;
  int            pend_rd = 0;
  int            mismatches;
  int            send_idle_pct;
  int            stall_pct;

  double_ended_queue #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DW)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_push_value     (in_push_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_front_value   (out_front_value),
    .out_back_value    (out_back_value),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty),
    .out_error_code    (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic deque_status_t apply_deque_cmd(logic [2:0] cmd, logic [DW-1:0] value);
    deque_status_t s;
    logic [3:0]    slot;
    s     = '0;
    s.err = ERR_NONE;
    case (cmd)
      CMD_PUSH_BACK: begin
        if (ring_fill == DEPTH) begin
          s.err = ERR_FULL;
        end else begin
          slot            = ring_head + ring_fill[3:0];
          ring_word[slot] = value;
          ring_fill       = ring_fill + 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (ring_fill == DEPTH) begin
          s.err = ERR_FULL;
        end else begin
          ring_head            = ring_head - 4'd1;
          ring_word[ring_head] = value;
          ring_fill            = ring_fill + 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (ring_fill == 0) s.err = ERR_EMPTY;
        else ring_fill = ring_fill - 1'b1;
      end
      CMD_POP_FRONT: begin
        if (ring_fill == 0) begin
          s.err = ERR_EMPTY;
        end else begin
          ring_head = ring_head + 4'd1;
          ring_fill = ring_fill - 1'b1;
        end
      end
      CMD_CLEAR: begin
        ring_head = '0;
        ring_fill = '0;
      end
      default: ;
    endcase
    s.count = ring_fill;
    s.empty = (ring_fill == 0);
    if (ring_fill != 0) begin
      // a full ring has fill[3:0] == 0, so the back lands just behind the head
      slot    = ring_head + ring_fill[3:0] - 4'd1;
      s.front = ring_word[ring_head];
      s.back  = ring_word[slot];
    end
    return s;
  endfunction

  function automatic logic [2:0] pick_command(bit filling);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 1) return CMD_CLEAR;
    if (roll < 4) return 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
    if (roll < (filling ? 66 : 32))
      return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
  endfunction

  function automatic logic [DW-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Called right after a rising edge; returns at the edge that accepts the transaction.
  task automatic send_cmd(input logic [2:0] cmd, input logic [DW-1:0] value,
                          input bit typed, input deque_status_t typed_status);
    deque_status_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_push_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_deque_cmd(cmd, value);
    pend_buf[pend_wr % PEND_DEPTH] = typed ? typed_status : predicted;
    pend_wr++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
  endtask

  always @(posedge clk) begin
    deque_status_t got;
    deque_status_t want;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      got.front = out_front_value;
      got.back  = out_back_value;
      got.count = out_element_count;
      got.empty = out_is_empty;
      got.err   = err_t'(out_error_code);
      if (pend_wr == pend_rd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected transaction front %h back %h count %0d %s %b err %0d",
                   got.front, got.back, got.count, "empty", got.empty, got.err);
      end else begin
        want = pend_buf[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (got.front !== want.front || got.back !== want.back || got.count !== want.count ||
            got.empty !== want.empty || got.err !== want.err) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected front %h back %h count %0d empty %b err %0d,",
                     want.front, want.back, want.count, want.empty, want.err);
            $display("          got front %h back %h count %0d empty %b err %0d",
                     got.front, got.back, got.count, got.empty, got.err);
          end
        end
      end
    end
  end

  initial begin
    bit filling;
    int run_left;
    in_valid      = 1'b0;
    in_cmd        = '0;
    in_push_value = '0;
    out_stall     = 1'b0;
    rst_n         = 1'b0;
    mismatches    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    ring_head     = '0;
    ring_fill     = '0;
    filling       = 1'b0;
    run_left      = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NROWS; r++)
      for (int k = 0; k < SCRIPT[r].reps; k++)
        send_cmd(SCRIPT[r].cmd, SCRIPT[r].value, SCRIPT[r].typed, SCRIPT[r].status);
    // hold off the sender until the directed results are all back
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 49; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        // alternate fill and drain runs so both full and empty get hit often
        if (run_left == 0) begin
          filling  = !filling;
          run_left = $urandom_range(20, 70);
        end
        run_left--;
        send_cmd(pick_command(filling), pick_word(), 1'b0, '0);
      end
      drain_results();
    end

    repeat (12) @(posedge clk);
    if (mismatches == 0 && pend_wr == pend_rd) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
